// File: hw/rtl/pwtm_pkg.sv
// Shared types and constants of the pulse width trimmed mean block.
// No dependencies; every other file refers to it by scoped names.
package pwtm_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int RING_DEPTH   = 6;
    localparam int RING_ENTRIES = NUM_CHANNELS * RING_DEPTH;

    localparam int CH_W    = 2;
    localparam int SLOT_W  = 3;
    localparam int ADDR_W  = 5;
    localparam int TIME_W  = 16;
    localparam int SUM_W   = 19;
    localparam int MEAN_W  = 14;
    localparam int COUNT_W = 32;

    localparam logic [TIME_W-1:0]  WRAP_ADD  = 16'hffff;
    localparam logic [MEAN_W-1:0]  OUT_MAX   = 14'h3fff;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hffff_ffff;
    localparam logic [SLOT_W-1:0]  LAST_SLOT = 3'd5;
    localparam logic [CH_W-1:0]    LAST_CH   = 2'd3;

    localparam logic [TIME_W-1:0] MAX_WIDTH_RST = 16'd10000;
    localparam logic [TIME_W-1:0] MIN_COUNT_RST = 16'd1000;

    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic REG_MAX_WIDTH = 1'b0;
    localparam logic REG_MIN_COUNT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EDGE,
        S_SCAN,
        S_FIN,
        S_OUT
    } t_state;

    // Control of the shared accumulate / min / max unit.
    typedef struct packed {
        logic acc;
        logic first;
    } t_trim_ctl;

endpackage

// File: hw/rtl/pwtm_capture.sv
// Edge capture, wrap width, acceptance, sample rings and pulse count.
// Depends on pwtm_pkg.
module pwtm_capture (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_edge_en,
    input  logic [pwtm_pkg::CH_W-1:0]     i_edge_ch,
    input  logic [pwtm_pkg::TIME_W-1:0]   i_edge_time,
    input  logic [pwtm_pkg::TIME_W-1:0]   i_max_width,
    input  logic [pwtm_pkg::CH_W-1:0]     i_rd_ch,
    input  logic [pwtm_pkg::SLOT_W-1:0]   i_rd_idx,
    output logic [pwtm_pkg::TIME_W-1:0]   o_rd_sample,
    output logic [pwtm_pkg::COUNT_W-1:0]  o_count
);

    logic                         r_fall [pwtm_pkg::NUM_CHANNELS];
    logic [pwtm_pkg::TIME_W-1:0]  r_rise [pwtm_pkg::NUM_CHANNELS];
    logic [pwtm_pkg::SLOT_W-1:0]  r_slot [pwtm_pkg::NUM_CHANNELS];
    logic [pwtm_pkg::TIME_W-1:0]  r_ring [pwtm_pkg::RING_ENTRIES];
    logic [pwtm_pkg::COUNT_W-1:0] r_count;

    logic [pwtm_pkg::TIME_W-1:0]  rise;
    logic [pwtm_pkg::TIME_W-1:0]  width;
    logic                         keep;
    logic [pwtm_pkg::SLOT_W-1:0]  slot;
    logic [pwtm_pkg::SLOT_W-1:0]  slot_next;
    logic [pwtm_pkg::ADDR_W-1:0]  wr_addr;
    logic [pwtm_pkg::ADDR_W-1:0]  rd_addr;

    // channel * 6 + slot, as shifts and adds
    function automatic logic [pwtm_pkg::ADDR_W-1:0] ring_addr(
        input logic [pwtm_pkg::CH_W-1:0]   ch,
        input logic [pwtm_pkg::SLOT_W-1:0] idx
    );
        logic [pwtm_pkg::ADDR_W-1:0] c;
        c = {{(pwtm_pkg::ADDR_W-pwtm_pkg::CH_W){1'b0}}, ch};
        return (c << 2) + (c << 1) + {{(pwtm_pkg::ADDR_W-pwtm_pkg::SLOT_W){1'b0}}, idx};
    endfunction

    always_comb begin
        rise = r_rise[i_edge_ch];
        // fall at or before rise: fall + 0xffff - rise always fits 16 bits
        if (i_edge_time > rise) begin
            width = i_edge_time - rise;
        end else begin
            width = i_edge_time + pwtm_pkg::WRAP_ADD - rise;
        end
        keep = width < i_max_width;
        slot = (r_slot[i_edge_ch] > pwtm_pkg::LAST_SLOT) ? '0 : r_slot[i_edge_ch];
        slot_next = (slot == pwtm_pkg::LAST_SLOT) ? '0 : slot + 3'd1;
        wr_addr = ring_addr(i_edge_ch, slot);
        rd_addr = ring_addr(i_rd_ch, i_rd_idx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < pwtm_pkg::NUM_CHANNELS; i++) begin
                r_fall[i] <= 1'b0;
                r_rise[i] <= '0;
                r_slot[i] <= '0;
            end
            for (int i = 0; i < pwtm_pkg::RING_ENTRIES; i++) begin
                r_ring[i] <= '0;
            end
            r_count <= '0;
        end else if (i_edge_en) begin
            if (r_fall[i_edge_ch]) begin
                if (keep) begin
                    r_ring[wr_addr]   <= width;
                    r_slot[i_edge_ch] <= slot_next;
                    if (r_count != pwtm_pkg::COUNT_MAX) begin
                        r_count <= r_count + 32'd1;
                    end
                end
                r_fall[i_edge_ch] <= 1'b0;
            end else begin
                r_rise[i_edge_ch] <= i_edge_time;
                r_fall[i_edge_ch] <= 1'b1;
            end
        end
    end

    assign o_rd_sample = r_ring[rd_addr];
    assign o_count     = r_count;

endmodule

// File: hw/rtl/pwtm_trim.sv
// Shared accumulate, minimum and maximum unit, one sample a cycle.
// Depends on pwtm_pkg; the mean of the accumulated samples without min and max is read at o_mean.
module pwtm_trim (
    input  logic                          i_clk,
    input  pwtm_pkg::t_trim_ctl           i_ctl,
    input  logic [pwtm_pkg::TIME_W-1:0]   i_sample,
    output logic [pwtm_pkg::MEAN_W-1:0]   o_mean
);

    logic [pwtm_pkg::SUM_W-1:0]  r_sum;
    logic [pwtm_pkg::TIME_W-1:0] r_hi;
    logic [pwtm_pkg::TIME_W-1:0] r_lo;
    logic [pwtm_pkg::SUM_W-1:0]  diff;
    logic [pwtm_pkg::SUM_W-3:0]  quarter;

    always_ff @(posedge i_clk) begin
        if (i_ctl.acc) begin
            if (i_ctl.first) begin
                r_sum <= {{(pwtm_pkg::SUM_W-pwtm_pkg::TIME_W){1'b0}}, i_sample};
                r_hi  <= i_sample;
                r_lo  <= i_sample;
            end else begin
                r_sum <= r_sum + {{(pwtm_pkg::SUM_W-pwtm_pkg::TIME_W){1'b0}}, i_sample};
                if (i_sample > r_hi) begin
                    r_hi <= i_sample;
                end
                if (i_sample < r_lo) begin
                    r_lo <= i_sample;
                end
            end
        end
    end

    // drop min and max, divide by four, clamp to the output range
    always_comb begin
        diff    = r_sum - {{(pwtm_pkg::SUM_W-pwtm_pkg::TIME_W){1'b0}}, r_hi}
                        - {{(pwtm_pkg::SUM_W-pwtm_pkg::TIME_W){1'b0}}, r_lo};
        quarter = diff[pwtm_pkg::SUM_W-1:2];
        if (quarter > {{(pwtm_pkg::SUM_W-2-pwtm_pkg::MEAN_W){1'b0}}, pwtm_pkg::OUT_MAX}) begin
            o_mean = pwtm_pkg::OUT_MAX;
        end else begin
            o_mean = quarter[pwtm_pkg::MEAN_W-1:0];
        end
    end

endmodule

// File: hw/rtl/pulse_width_trimmed_mean_top.sv
// Top level of the pulse width trimmed mean block: APB registers, sequencer
// and output register. Depends on pwtm_pkg, pwtm_capture and pwtm_trim.
//
//   channel  | signals                                   | moves
//   ---------+-------------------------------------------+-------------------------
//   in       | i_in_valid, o_in_stall, i_cmd ...         | edge event or read request
//   out      | o_out_valid, i_out_stall, o_width_* ...   | one result per read
//   config   | psel, penable, pwrite, paddr, pwdata ...  | register write / read
//
// An edge request is accepted, then one update of the channel state in S_EDGE.
// A read request is accepted, then per channel the six ring samples are scanned
// through the shared trim unit and one finish step follows, then one output load.
// Reset clears all channel state and the rings at once in flip-flops.
// A result waits in the output register under i_out_stall; a new request is
// taken meanwhile, and a read finishing behind it holds until the slot frees.
module pulse_width_trimmed_mean_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_cmd,
    input  logic [pwtm_pkg::CH_W-1:0]     i_channel,
    input  logic [pwtm_pkg::TIME_W-1:0]   i_capture_time,

    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [pwtm_pkg::MEAN_W-1:0]   o_width_first,
    output logic [pwtm_pkg::MEAN_W-1:0]   o_width_second,
    output logic [pwtm_pkg::MEAN_W-1:0]   o_width_third,
    output logic [pwtm_pkg::MEAN_W-1:0]   o_width_fourth,
    output logic [pwtm_pkg::COUNT_W-1:0]  o_pulse_total,
    output logic                          o_too_few_pulses,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    pwtm_pkg::t_state             r_state, n_state;
    logic [pwtm_pkg::CH_W-1:0]    r_ch, n_ch;
    logic [pwtm_pkg::SLOT_W-1:0]  r_idx, n_idx;
    logic [pwtm_pkg::CH_W-1:0]    r_edge_ch;
    logic [pwtm_pkg::TIME_W-1:0]  r_edge_time;
    logic [pwtm_pkg::TIME_W-1:0]  r_max_width;
    logic [pwtm_pkg::TIME_W-1:0]  r_min_count;
    logic [pwtm_pkg::MEAN_W-1:0]  r_width [pwtm_pkg::NUM_CHANNELS];
    logic                         r_out_valid;

    logic                         accept;
    logic                         edge_en;
    logic                         fin;
    logic                         load_out;
    pwtm_pkg::t_trim_ctl          trim_ctl;
    logic [pwtm_pkg::TIME_W-1:0]  sample;
    logic [pwtm_pkg::MEAN_W-1:0]  mean;
    logic [pwtm_pkg::COUNT_W-1:0] count;
    logic                         cfg_wr;

    // ---------------------------------------------------------------
    // Configuration registers: index is paddr[2], written on access.
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_width <= pwtm_pkg::MAX_WIDTH_RST;
            r_min_count <= pwtm_pkg::MIN_COUNT_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                pwtm_pkg::REG_MAX_WIDTH: r_max_width <= pwdata[15:0];
                pwtm_pkg::REG_MIN_COUNT: r_min_count <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            pwtm_pkg::REG_MAX_WIDTH: prdata = {16'b0, r_max_width};
            pwtm_pkg::REG_MIN_COUNT: prdata = {16'b0, r_min_count};
            default:                 prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    assign o_in_stall = (r_state != pwtm_pkg::S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pwtm_pkg::S_IDLE;
            r_ch    <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_ch     = r_ch;
        n_idx    = r_idx;
        edge_en  = 1'b0;
        fin      = 1'b0;
        load_out = 1'b0;
        trim_ctl = '0;
        unique case (r_state)
            pwtm_pkg::S_IDLE: begin
                if (accept) begin
                    n_ch  = '0;
                    n_idx = '0;
                    n_state = (i_cmd == pwtm_pkg::CMD_READ) ? pwtm_pkg::S_SCAN
                                                            : pwtm_pkg::S_EDGE;
                end
            end
            pwtm_pkg::S_EDGE: begin
                edge_en = 1'b1;
                n_state = pwtm_pkg::S_IDLE;
            end
            pwtm_pkg::S_SCAN: begin
                // feed one ring sample per cycle into the trim unit
                trim_ctl.acc   = 1'b1;
                trim_ctl.first = (r_idx == '0);
                if (r_idx == pwtm_pkg::LAST_SLOT) begin
                    n_state = pwtm_pkg::S_FIN;
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
            pwtm_pkg::S_FIN: begin
                fin   = 1'b1;
                n_idx = '0;
                if (r_ch == pwtm_pkg::LAST_CH) begin
                    n_state = pwtm_pkg::S_OUT;
                end else begin
                    n_ch    = r_ch + 2'd1;
                    n_state = pwtm_pkg::S_SCAN;
                end
            end
            pwtm_pkg::S_OUT: begin
                // hold until the output register is free or being taken
                if (!r_out_valid || !i_out_stall) begin
                    load_out = 1'b1;
                    n_state  = pwtm_pkg::S_IDLE;
                end
            end
            default: n_state = pwtm_pkg::S_IDLE;
        endcase
    end

    // latch the edge request for the update cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_edge_ch   <= i_channel;
            r_edge_time <= i_capture_time;
        end
    end

    pwtm_capture u_capture (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_edge_en   (edge_en),
        .i_edge_ch   (r_edge_ch),
        .i_edge_time (r_edge_time),
        .i_max_width (r_max_width),
        .i_rd_ch     (r_ch),
        .i_rd_idx    (r_idx),
        .o_rd_sample (sample),
        .o_count     (count)
    );

    pwtm_trim u_trim (
        .i_clk    (i_clk),
        .i_ctl    (trim_ctl),
        .i_sample (sample),
        .o_mean   (mean)
    );

    // hold each channel's mean until the whole read is done
    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_width[r_ch] <= mean;
        end
    end

    // ---------------------------------------------------------------
    // Output register: channels leave in the order 0, 1, 3, 2.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_width_first    <= r_width[0];
            o_width_second   <= r_width[1];
            o_width_third    <= r_width[3];
            o_width_fourth   <= r_width[2];
            o_pulse_total    <= count;
            o_too_few_pulses <= count < {16'b0, r_min_count};
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
